// ===== hdl/vei_pkg.sv =====
`default_nettype none

package vei_pkg;

  // Store geometry
  localparam int unsigned DIM_X  = 32;
  localparam int unsigned DIM_Y  = 32;
  localparam int unsigned DIM_Z  = 32;
  localparam int unsigned DEPTH  = DIM_X * DIM_Y * DIM_Z;
  localparam int unsigned ADDR_W = $clog2(DEPTH);

  // Field widths
  localparam int unsigned POS_W   = 5;
  localparam int unsigned CRD_W   = 6;
  localparam int unsigned SIZE_W  = 6;
  localparam int unsigned VOXEL_W = 16;
  localparam int unsigned SQ_W    = 2 * VOXEL_W;
  localparam int unsigned ACC_W   = SQ_W + 2;

  // Reads per query: low and high neighbor on each of three axes
  localparam int unsigned READS = 6;
  localparam int unsigned RCNT_W = 3;

  // Edge weight = DIVIDEND / (4 + D)
  localparam int unsigned DIVIDEND      = 262144;
  localparam int unsigned DIV_W         = 19;
  localparam int unsigned QUO_W         = 17;
  localparam int unsigned QFULL_W       = 18;
  localparam int unsigned BITS_PER_STEP = 3;
  localparam int unsigned DIV_STEPS     = QFULL_W / BITS_PER_STEP;
  localparam int unsigned STEP_W        = 3;

  // Queries allowed between accept and result delivery
  localparam int unsigned MAX_INFLIGHT = 3;
  localparam int unsigned INFL_W       = 2;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Z = 2'd2;
  localparam logic [SIZE_W-1:0] SIZE_RESET = 6'd32;

  // Input kinds
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef enum logic {
    FE_IDLE,
    FE_READ
  } fe_state_t;

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_RUN,
    DIV_DONE
  } div_state_t;

  typedef struct packed {
    logic             valid;
    logic [DIV_W-1:0] divisor;
    logic             zero;
    logic             oor;
  } div_req_t;

  typedef struct packed {
    logic             valid;
    logic [QUO_W-1:0] quotient;
    logic             oor;
  } div_res_t;

endpackage

`default_nettype wire

// ===== hdl/vei_div.sv =====
`default_nettype none

module vei_div (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire vei_pkg::div_req_t req,
  output logic                   req_ready,
  output vei_pkg::div_res_t      res,
  input  wire logic              res_ready
);
  import vei_pkg::*;

  div_state_t state, state_next;

  logic [DIV_W-1:0]   rem, rem_next;
  logic [QFULL_W-1:0] quo, quo_next;
  logic [DIV_W-1:0]   dvs;
  logic [STEP_W-1:0]  step;
  logic               oor;
  logic               load;

  always_comb begin
    state_next = state;
    req_ready  = 1'b0;
    case (state)
      DIV_IDLE: req_ready = 1'b1;
      DIV_RUN: begin
        if (step == STEP_W'(DIV_STEPS - 1)) begin
          state_next = DIV_DONE;
        end
      end
      DIV_DONE: begin
        req_ready = res_ready;
        if (res_ready) begin
          state_next = DIV_IDLE;
        end
      end
      default: state_next = DIV_IDLE;
    endcase
    load = req.valid && req_ready;
    if (load) begin
      state_next = req.zero ? DIV_DONE : DIV_RUN;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= DIV_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Restoring division, BITS_PER_STEP quotient bits per cycle; the remainder stays below the divisor
  always_comb begin
    logic [DIV_W-1:0] t;
    rem_next = rem;
    quo_next = quo;
    for (int i = 0; i < BITS_PER_STEP; i++) begin
      t = {rem_next[DIV_W-2:0], 1'b0};
      if (t >= dvs) begin
        rem_next = t - dvs;
        quo_next = {quo_next[QFULL_W-2:0], 1'b1};
      end else begin
        rem_next = t;
        quo_next = {quo_next[QFULL_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      // the top dividend bit is already consumed: remainder one
      rem  <= DIV_W'(1);
      quo  <= '0;
      dvs  <= req.divisor;
      step <= '0;
      oor  <= req.oor;
    end else if (state == DIV_RUN) begin
      rem  <= rem_next;
      quo  <= quo_next;
      step <= step + STEP_W'(1);
    end
  end

  assign res.valid    = (state == DIV_DONE);
  assign res.quotient = quo[QUO_W-1:0];
  assign res.oor      = oor;

endmodule

`default_nettype wire

// ===== hdl/volume_edge_indicator_core.sv =====
`default_nettype none

// A query whose weight is known to be zero skips the run state of the divider.
// Queries are paced by six neighbor reads through the single voxel memory read port;
// writes and queries are taken only outside read phases, below MAX_INFLIGHT open queries.
// The divider returns three quotient bits a cycle and keeps pace with the reads.
// Reset (synchronous, active high) clears control state and sets each size to 32;
// the voxel memory is not cleared and is undefined until written.
module volume_edge_indicator_core (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [vei_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [vei_pkg::SIZE_W-1:0]    cfg_data,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          kind,
  input  wire logic [vei_pkg::POS_W-1:0]     pos_x,
  input  wire logic [vei_pkg::POS_W-1:0]     pos_y,
  input  wire logic [vei_pkg::POS_W-1:0]     pos_z,
  input  wire logic [vei_pkg::VOXEL_W-1:0]   voxel,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [vei_pkg::QUO_W-1:0]          edge_weight,
  output logic                               out_of_range
);
  import vei_pkg::*;

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [CRD_W-1:0] x,
                                                  input logic [CRD_W-1:0] y,
                                                  input logic [CRD_W-1:0] z);
    return ADDR_W'(32'(x) + DIM_X * (32'(y) + DIM_Y * 32'(z)));
  endfunction

  function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] r,
                                                 input int unsigned dim);
    if (r == '0) return SIZE_W'(1);
    if (32'(r) > dim) return SIZE_W'(dim);
    return r;
  endfunction

  // Configuration
  logic [SIZE_W-1:0] size_x, size_y, size_z;
  logic [SIZE_W-1:0] sx, sy, sz;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      size_x <= SIZE_RESET;
      size_y <= SIZE_RESET;
      size_z <= SIZE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SIZE_X: size_x <= cfg_data;
        CFG_SIZE_Y: size_y <= cfg_data;
        CFG_SIZE_Z: size_z <= cfg_data;
        default: ;
      endcase
    end
  end

  assign sx = eff_size(size_x, DIM_X);
  assign sy = eff_size(size_y, DIM_Y);
  assign sz = eff_size(size_z, DIM_Z);

  // Front end
  fe_state_t         fe_state, fe_state_next;
  logic [INFL_W-1:0] inflight;
  logic              in_take, query_take, out_take;
  logic              rd_en, mem_we, in_store;
  logic [RCNT_W-1:0] rd_cnt;

  always_comb begin
    fe_state_next = fe_state;
    in_ready      = 1'b0;
    rd_en         = 1'b0;
    case (fe_state)
      FE_IDLE: begin
        in_ready = (32'(inflight) < MAX_INFLIGHT);
        if (in_valid && in_ready && kind == KIND_QUERY) begin
          fe_state_next = FE_READ;
        end
      end
      FE_READ: begin
        rd_en = 1'b1;
        if (rd_cnt == RCNT_W'(READS - 1)) begin
          fe_state_next = FE_IDLE;
        end
      end
      default: fe_state_next = FE_IDLE;
    endcase
  end

  assign in_take    = in_valid && in_ready;
  assign query_take = in_take && (kind == KIND_QUERY);
  assign in_store   = (32'(pos_x) < DIM_X) && (32'(pos_y) < DIM_Y) && (32'(pos_z) < DIM_Z);
  // writes land only while no read phase is open, so reads never race them
  assign mem_we     = in_take && (kind == KIND_WRITE) && in_store;
  assign out_take   = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      fe_state <= FE_IDLE;
      rd_cnt   <= '0;
      inflight <= '0;
    end else begin
      fe_state <= fe_state_next;
      if (query_take) begin
        rd_cnt <= '0;
      end else if (rd_en) begin
        rd_cnt <= rd_cnt + RCNT_W'(1);
      end
      case ({query_take, out_take})
        2'b10:   inflight <= inflight + INFL_W'(1);
        2'b01:   inflight <= inflight - INFL_W'(1);
        default: ;
      endcase
    end
  end

  // Clamped neighbor coordinates, latched at accept
  logic [CRD_W-1:0] px, py, pz;
  logic [CRD_W-1:0] lx, hx, ly, hy, lz, hz;
  logic [CRD_W-1:0] q_x, q_y, q_z, q_lx, q_hx, q_ly, q_hy, q_lz, q_hz;
  logic             q_oor;

  assign px = CRD_W'(pos_x);
  assign py = CRD_W'(pos_y);
  assign pz = CRD_W'(pos_z);
  assign lx = (px != '0) ? px - CRD_W'(1) : '0;
  assign ly = (py != '0) ? py - CRD_W'(1) : '0;
  assign lz = (pz != '0) ? pz - CRD_W'(1) : '0;
  assign hx = (px + CRD_W'(1) < sx) ? px + CRD_W'(1) : sx - CRD_W'(1);
  assign hy = (py + CRD_W'(1) < sy) ? py + CRD_W'(1) : sy - CRD_W'(1);
  assign hz = (pz + CRD_W'(1) < sz) ? pz + CRD_W'(1) : sz - CRD_W'(1);

  always_ff @(posedge clk) begin
    if (query_take) begin
      q_x   <= px;
      q_y   <= py;
      q_z   <= pz;
      q_lx  <= lx;
      q_hx  <= hx;
      q_ly  <= ly;
      q_hy  <= hy;
      q_lz  <= lz;
      q_hz  <= hz;
      q_oor <= (px >= sx) || (py >= sy) || (pz >= sz);
    end
  end

  // Voxel memory: one write port, one registered read port
  logic [VOXEL_W-1:0] mem [DEPTH];
  logic [ADDR_W-1:0]  wr_addr, rd_addr;
  logic [VOXEL_W-1:0] rd_data;

  assign wr_addr = cell_addr(px, py, pz);

  always_comb begin
    case (rd_cnt)
      3'd0:    rd_addr = cell_addr(q_hx, q_y, q_z);
      3'd1:    rd_addr = cell_addr(q_lx, q_y, q_z);
      3'd2:    rd_addr = cell_addr(q_x, q_hy, q_z);
      3'd3:    rd_addr = cell_addr(q_x, q_ly, q_z);
      3'd4:    rd_addr = cell_addr(q_x, q_y, q_hz);
      default: rd_addr = cell_addr(q_x, q_y, q_lz);
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= voxel;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Difference, square and accumulate pipeline
  logic               rd_vld, rd_oor;
  logic [RCNT_W-1:0]  rd_idx;
  logic [VOXEL_W-1:0] prev_data, diff;
  logic               diff_vld, diff_first, diff_last, diff_oor;
  logic [SQ_W-1:0]    sq;
  logic               sq_vld, sq_first, sq_last, sq_oor;
  logic [ACC_W-1:0]   acc;
  logic               acc_done, acc_oor;

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld   <= 1'b0;
      diff_vld <= 1'b0;
      sq_vld   <= 1'b0;
      acc_done <= 1'b0;
    end else begin
      rd_vld   <= rd_en;
      diff_vld <= rd_vld && rd_idx[0];
      sq_vld   <= diff_vld;
      acc_done <= sq_vld && sq_last;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx <= rd_cnt;
    rd_oor <= q_oor;
    if (rd_vld && !rd_idx[0]) begin
      prev_data <= rd_data;
    end
    // pair complete: take the absolute difference
    if (rd_vld && rd_idx[0]) begin
      diff       <= (rd_data >= prev_data) ? rd_data - prev_data : prev_data - rd_data;
      diff_first <= (rd_idx == RCNT_W'(1));
      diff_last  <= (rd_idx == RCNT_W'(READS - 1));
      diff_oor   <= rd_oor;
    end
    sq       <= SQ_W'(diff) * SQ_W'(diff);
    sq_first <= diff_first;
    sq_last  <= diff_last;
    sq_oor   <= diff_oor;
    if (sq_vld) begin
      acc     <= sq_first ? ACC_W'(sq) : acc + ACC_W'(sq);
      acc_oor <= sq_oor;
    end
  end

  // Hold one finished sum until the divider takes it
  div_req_t pend;
  div_res_t res;
  logic     div_ready, pend_take, res_ready;

  assign pend_take = pend.valid && div_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend.valid <= 1'b0;
    end else if (acc_done) begin
      pend.valid <= 1'b1;
    end else if (pend_take) begin
      pend.valid <= 1'b0;
    end
    if (acc_done) begin
      pend.divisor <= DIV_W'(acc + ACC_W'(4));
      // a divisor above the dividend gives zero
      pend.zero    <= acc_oor || (acc > ACC_W'(DIVIDEND - 4));
      pend.oor     <= acc_oor;
    end
  end

  vei_div u_div (
    .clk       (clk),
    .rst       (rst),
    .req       (pend),
    .req_ready (div_ready),
    .res       (res),
    .res_ready (res_ready)
  );

  // Output register
  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res.valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid && res_ready) begin
      edge_weight  <= res.quotient;
      out_of_range <= res.oor;
    end
  end

`ifndef SYNTHESIS
  a_pend_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    acc_done && pend.valid |-> pend_take)
    else $error("finished sum arrived while the previous one still waits");

  a_out_has_query: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> inflight != '0)
    else $error("result shown with no query in flight");

  a_write_no_read: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> !rd_en)
    else $error("voxel write during a read phase");

  a_read_follows_query: assert property (@(posedge clk) disable iff (rst)
    query_take |=> rd_en && rd_cnt == '0)
    else $error("read phase did not start after query accept");
`endif

endmodule

`default_nettype wire
